// ----- sv/pma_pkg.sv -----
// pma_pkg: types and constants for the pointer motion acceleration block
// no dependencies; used by pointer_motion_acceleration
package pma_pkg;

  // configuration register indexes
  localparam logic [2:0] RegPreScaleX   = 3'd0;
  localparam logic [2:0] RegPreScaleY   = 3'd1;
  localparam logic [2:0] RegPostScaleX  = 3'd2;
  localparam logic [2:0] RegPostScaleY  = 3'd3;
  localparam logic [2:0] RegAccelPerSpd = 3'd4;
  localparam logic [2:0] RegSpeedOffset = 3'd5;
  localparam logic [2:0] RegDistanceCap = 3'd6;
  localparam logic [2:0] RegGainCap     = 3'd7;

  localparam logic [15:0] ScaleOne    = 16'd4096;
  localparam logic [7:0]  IntervalMax = 8'd200;
  localparam logic [7:0]  IntervalMin = 8'd1;
  localparam logic [28:0] GainOne     = 29'd65536;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DIV, S_SQRT,
    S_AX, S_AY, S_SQY, S_SQRT0, S_LEN,
    S_CAPX_D, S_CAPX, S_CAPY_D, S_CAPY,
    S_SPD, S_GAIN0, S_GAIN1,
    S_VX1, S_VX2, S_VY1, S_VY2, S_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] out;
    logic [16:0] carry;
  } fin_t;

endpackage

// ----- sv/pointer_motion_acceleration.sv -----
// pointer_motion_acceleration: mouse report acceleration with distance and gain caps
// depends on pma_pkg (state type, register indexes, constants)
//
// channel  dir  handshake               payload
// s_       in   s_tvalid_i/s_tready_o   s_tdata_i  {elapsed_ms, dy, dx}
// m_       out  m_tvalid_o/m_tready_i   m_tdata_o  {out_y, out_x}
// cfg_     in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a report is accepted only in the idle state, so the next one waits until the
// sequencer returns there; the gain multiply is skipped when the speed is not
// positive and the distance cap, when it engages, adds two multiplies and two
// divides; all steps share the single shift-add / shift-subtract unit that
// retires one multiplier bit, quotient bit or root bit per cycle
// reset: registers to defaults, carries to zero, last interval to 1 ms
// a finished beat waits in the output register while the next report is taken;
// the sequencer holds in its final state only if that register is still full
module pointer_motion_acceleration (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [7:0] dx, [15:8] dy, [31:16] elapsed_ms
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [15:0] out_x, [31:16] out_y
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic [15:0] pre_x_q, pre_y_q, post_x_q, post_y_q;
  logic [15:0] aps_q, offset_q, dcap_q, gcap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_x_q  <= pma_pkg::ScaleOne;
      pre_y_q  <= pma_pkg::ScaleOne;
      post_x_q <= pma_pkg::ScaleOne;
      post_y_q <= pma_pkg::ScaleOne;
      aps_q    <= '0;
      offset_q <= '0;
      dcap_q   <= '0;
      gcap_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pma_pkg::RegPreScaleX:   pre_x_q  <= cfg_data_i;
        pma_pkg::RegPreScaleY:   pre_y_q  <= cfg_data_i;
        pma_pkg::RegPostScaleX:  post_x_q <= cfg_data_i;
        pma_pkg::RegPostScaleY:  post_y_q <= cfg_data_i;
        pma_pkg::RegAccelPerSpd: aps_q    <= cfg_data_i;
        pma_pkg::RegSpeedOffset: offset_q <= cfg_data_i;
        pma_pkg::RegDistanceCap: dcap_q   <= cfg_data_i;
        pma_pkg::RegGainCap:     gcap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and serial datapath
  pma_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [63:0] acc_q, acc_d;     // product / dividend-quotient / radicand
  logic [63:0] opa_q, opa_d;     // multiplicand / divisor / root
  logic [31:0] opb_q, opb_d;     // multiplier bits, lsb first
  logic [27:0] rem_q, rem_d;     // partial remainder
  logic [5:0]  cnt_q, cnt_d;
  logic [26:0] px_q, px_d, py_q, py_d;
  logic        sx_q, sx_d, sy_q, sy_d;
  logic [27:0] len_q, len_d;
  logic [28:0] gain_q, gain_d;
  logic [43:0] vx_q, vx_d, vy_q, vy_d;
  logic [7:0]  last_q, last_d;
  logic [16:0] cx_q, cx_d, cy_q, cy_d;
  logic        mv_q, mv_d;
  logic [15:0] ox_q, ox_d, oy_q, oy_d;

  // step helpers
  logic [63:0] sq_bit, sq_try;
  logic [28:0] div_try;
  logic [7:0]  dx_mag, dy_mag, ms_sel;
  logic [29:0] speed;
  logic [28:0] gain_raw, gain_lim;
  pma_pkg::fin_t fin_x, fin_y;

  // round half away from zero, keep residue, saturate
  function automatic pma_pkg::fin_t finish(input logic neg, input logic [43:0] mag,
                                           input logic [16:0] carry);
    logic [45:0] t, tm, r, ri, rem;
    pma_pkg::fin_t f;
    t   = (neg ? (46'd0 - {2'b00, mag}) : {2'b00, mag}) + {{29{carry[16]}}, carry};
    tm  = t[45] ? (46'd0 - t) : t;
    r   = (tm + 46'd32768) >> 16;
    ri  = t[45] ? (46'd0 - r) : r;
    rem = t - (ri << 16);
    f.carry = rem[16:0];
    if (!t[45] && (r > 46'd32767)) f.out = 16'h7fff;
    else if (t[45] && (r > 46'd32768)) f.out = 16'h8000;
    else f.out = ri[15:0];
    return f;
  endfunction

  assign sq_bit  = 64'd1 << {cnt_q[4:0], 1'b0};
  assign sq_try  = opa_q + sq_bit;
  assign div_try = {rem_q, acc_q[55]};
  assign dx_mag  = s_tdata_i[7]  ? (8'd0 - s_tdata_i[7:0])  : s_tdata_i[7:0];
  assign dy_mag  = s_tdata_i[15] ? (8'd0 - s_tdata_i[15:8]) : s_tdata_i[15:8];
  assign speed   = {2'b00, acc_q[27:0]} - {6'd0, offset_q, 8'd0};
  assign gain_raw = pma_pkg::GainOne + acc_q[44:16];
  assign gain_lim = ((gcap_q != 16'd0) && (gain_raw >= {5'd0, gcap_q, 8'd0}))
                  ? {5'd0, gcap_q, 8'd0} : gain_raw;
  assign fin_x = finish(sx_q, vx_q, cx_q);
  assign fin_y = finish(sy_q, vy_q, cy_q);

  // interval: zero falls back to the last one, long gaps clamp
  always_comb begin
    ms_sel = s_tdata_i[31:16] == 16'd0 ? last_q
           : (s_tdata_i[31:16] > {8'd0, pma_pkg::IntervalMax}) ? pma_pkg::IntervalMax
           : s_tdata_i[23:16];
    if (ms_sel < pma_pkg::IntervalMin) ms_sel = pma_pkg::IntervalMin;
  end

  assign s_tready_o = (state_q == pma_pkg::S_IDLE);
  assign m_tvalid_o = mv_q;
  assign m_tdata_o  = {oy_q, ox_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pma_pkg::S_IDLE;
      ret_q   <= pma_pkg::S_IDLE;
      cnt_q   <= '0;
      last_q  <= pma_pkg::IntervalMin;
      cx_q    <= '0;
      cy_q    <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    rem_q  <= rem_d;
    px_q   <= px_d;
    py_q   <= py_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    len_q  <= len_d;
    gain_q <= gain_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; cnt_d = cnt_q;
    acc_d = acc_q; opa_d = opa_q; opb_d = opb_q; rem_d = rem_q;
    px_d = px_q; py_d = py_q; sx_d = sx_q; sy_d = sy_q;
    len_d = len_q; gain_d = gain_q; vx_d = vx_q; vy_d = vy_q;
    last_d = last_q; cx_d = cx_q; cy_d = cy_q;
    mv_d = mv_q; ox_d = ox_q; oy_d = oy_q;

    if (mv_q && m_tready_i) mv_d = 1'b0;

    case (state_q)
      pma_pkg::S_IDLE: begin
        if (s_tvalid_i) begin
          sx_d   = s_tdata_i[7];
          sy_d   = s_tdata_i[15];
          py_d   = {19'd0, dy_mag};
          last_d = ms_sel;
          acc_d  = '0;
          opa_d  = {48'd0, pre_x_q};
          opb_d  = {24'd0, dx_mag};
          cnt_d  = 6'd7;
          ret_d  = pma_pkg::S_AX;
          state_d = pma_pkg::S_MUL;
        end
      end
      // one multiplier bit per cycle
      pma_pkg::S_MUL: begin
        if (opb_q[0]) acc_d = acc_q + opa_q;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = ret_q;
      end
      // restoring division, one quotient bit per cycle
      pma_pkg::S_DIV: begin
        if (div_try >= {1'b0, opa_q[27:0]}) begin
          rem_d = div_try[27:0] - opa_q[27:0];
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = div_try[27:0];
          acc_d = {acc_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = ret_q;
      end
      // digit-by-digit square root, one root bit per cycle
      pma_pkg::S_SQRT: begin
        if (acc_q >= sq_try) begin
          acc_d = acc_q - sq_try;
          opa_d = (opa_q >> 1) + sq_bit;
        end else begin
          opa_d = opa_q >> 1;
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = pma_pkg::S_LEN;
      end
      pma_pkg::S_AX: begin
        px_d  = {acc_q[22:0], 4'd0};
        acc_d = '0;
        opa_d = {48'd0, pre_y_q};
        opb_d = {24'd0, py_q[7:0]};
        cnt_d = 6'd7;
        ret_d = pma_pkg::S_AY;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_AY: begin
        py_d  = {acc_q[22:0], 4'd0};
        acc_d = '0;
        opa_d = {37'd0, px_q};
        opb_d = {5'd0, px_q};
        cnt_d = 6'd26;
        ret_d = pma_pkg::S_SQY;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_SQY: begin
        // accumulate y squared on top of x squared
        opa_d = {37'd0, py_q};
        opb_d = {5'd0, py_q};
        cnt_d = 6'd26;
        ret_d = pma_pkg::S_SQRT0;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_SQRT0: begin
        opa_d = '0;
        cnt_d = 6'd27;
        state_d = pma_pkg::S_SQRT;
      end
      pma_pkg::S_LEN: begin
        len_d = opa_q[27:0];
        if ((dcap_q != 16'd0) && (opa_q[27:0] >= {dcap_q, 12'd0})) begin
          acc_d = '0;
          opa_d = {37'd0, px_q};
          opb_d = {16'd0, dcap_q};
          cnt_d = 6'd15;
          ret_d = pma_pkg::S_CAPX_D;
          state_d = pma_pkg::S_MUL;
        end else begin
          state_d = pma_pkg::S_SPD;
        end
      end
      pma_pkg::S_CAPX_D: begin
        acc_d = {acc_q[51:0], 12'd0};
        rem_d = '0;
        opa_d = {36'd0, len_q};
        cnt_d = 6'd55;
        ret_d = pma_pkg::S_CAPX;
        state_d = pma_pkg::S_DIV;
      end
      pma_pkg::S_CAPX: begin
        px_d  = acc_q[26:0];
        acc_d = '0;
        opa_d = {37'd0, py_q};
        opb_d = {16'd0, dcap_q};
        cnt_d = 6'd15;
        ret_d = pma_pkg::S_CAPY_D;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_CAPY_D: begin
        acc_d = {acc_q[51:0], 12'd0};
        rem_d = '0;
        opa_d = {36'd0, len_q};
        cnt_d = 6'd55;
        ret_d = pma_pkg::S_CAPY;
        state_d = pma_pkg::S_DIV;
      end
      pma_pkg::S_CAPY: begin
        py_d = acc_q[26:0];
        state_d = pma_pkg::S_SPD;
      end
      pma_pkg::S_SPD: begin
        // length per millisecond, dividend at the top of the shifter
        acc_d = {8'd0, len_q, 28'd0};
        rem_d = '0;
        opa_d = {56'd0, last_q};
        cnt_d = 6'd27;
        ret_d = pma_pkg::S_GAIN0;
        state_d = pma_pkg::S_DIV;
      end
      pma_pkg::S_GAIN0: begin
        if (!speed[29] && (speed != 30'd0)) begin
          acc_d = '0;
          opa_d = {36'd0, speed[27:0]};
          opb_d = {16'd0, aps_q};
          cnt_d = 6'd15;
          ret_d = pma_pkg::S_GAIN1;
          state_d = pma_pkg::S_MUL;
        end else begin
          acc_d = '0;
          state_d = pma_pkg::S_GAIN1;
        end
      end
      pma_pkg::S_GAIN1: begin
        gain_d = gain_lim;
        acc_d  = '0;
        opa_d  = {37'd0, px_q};
        opb_d  = {3'd0, gain_lim};
        cnt_d  = 6'd28;
        ret_d  = pma_pkg::S_VX1;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_VX1: begin
        opa_d = {24'd0, acc_q[55:16]};
        acc_d = '0;
        opb_d = {16'd0, post_x_q};
        cnt_d = 6'd15;
        ret_d = pma_pkg::S_VX2;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_VX2: begin
        vx_d  = acc_q[55:12];
        acc_d = '0;
        opa_d = {37'd0, py_q};
        opb_d = {3'd0, gain_q};
        cnt_d = 6'd28;
        ret_d = pma_pkg::S_VY1;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_VY1: begin
        opa_d = {24'd0, acc_q[55:16]};
        acc_d = '0;
        opb_d = {16'd0, post_y_q};
        cnt_d = 6'd15;
        ret_d = pma_pkg::S_VY2;
        state_d = pma_pkg::S_MUL;
      end
      pma_pkg::S_VY2: begin
        vy_d = acc_q[55:12];
        state_d = pma_pkg::S_DONE;
      end
      // round, keep residues, hand the beat to the output register
      pma_pkg::S_DONE: begin
        if (!mv_q || m_tready_i) begin
          mv_d = 1'b1;
          ox_d = fin_x.out;
          oy_d = fin_y.out;
          cx_d = fin_x.carry;
          cy_d = fin_y.carry;
          state_d = pma_pkg::S_IDLE;
        end
      end
      default: state_d = pma_pkg::S_IDLE;
    endcase
  end

endmodule
